/* design/wfn_pkg.sv */
package wfn_pkg;

    localparam int MAX_WINDOW_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_W            = 9;
    localparam int OUT_W            = 32;

    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
    } t_q_cmd;

    typedef struct packed {
        logic head_valid;
        logic next_valid;
    } t_q_stat;

endpackage

/* design/wfn_ifs.sv */
interface wfn_in_if import wfn_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           starts_sequence;

    modport source (output valid, output sample, output starts_sequence, input ready);
    modport sink   (input valid, input sample, input starts_sequence, output ready);
endinterface

interface wfn_out_if import wfn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] first_negative;

    modport source (output valid, output first_negative, input ready);
    modport sink   (input valid, input first_negative, output ready);
endinterface

interface wfn_cfg_if import wfn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

/* design/wfn_ram.sv */
module wfn_ram import wfn_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = MAX_WINDOW_DEF,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/wfn_queue.sv */
module wfn_queue import wfn_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int PW           = $clog2(2 * MAX_WINDOW)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_q_cmd                         i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_push_value,
    input  logic [PW-1:0]                  i_push_pos,
    output t_q_stat                        o_stat,
    output logic [PW-1:0]                  o_head_pos,
    output logic signed [SAMPLE_WIDTH-1:0] o_next_value
);

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNTW = $clog2(MAX_WINDOW + 1);
    localparam int EW   = SAMPLE_WIDTH + PW;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(MAX_WINDOW - 1)) begin
            r = '0;
        end else begin
            r = a + AW'(1);
        end
        return r;
    endfunction

    logic [AW-1:0]   r_head, r_tail, n_head, n_tail;
    logic [CNTW-1:0] r_count, n_count, cnt_eff, c1;
    logic [EW-1:0]   r_h0, r_h1, n_h0, n_h1;
    logic [EW-1:0]   r_fwd;
    logic            r_fwd_hit;
    logic [EW-1:0]   push_e, e2, a0, a1, rd_data;
    logic [AW-1:0]   head_base, wr_addr, rd_addr;

    assign push_e = {i_push_value, i_push_pos};
    assign e2     = r_fwd_hit ? r_fwd : rd_data;

    always_comb begin
        cnt_eff   = i_cmd.clear ? '0 : r_count;
        c1        = cnt_eff - CNTW'(i_cmd.pop);
        a0        = i_cmd.pop ? r_h1 : r_h0;
        a1        = i_cmd.pop ? e2 : r_h1;
        n_h0      = (c1 != '0) ? a0 : push_e;
        n_h1      = (32'(c1) >= 32'd2) ? a1 : push_e;
        n_count   = c1 + CNTW'(i_cmd.push);
        head_base = i_cmd.clear ? '0 : r_head;
        n_head    = i_cmd.pop ? ptr_inc(head_base) : head_base;
        wr_addr   = i_cmd.clear ? '0 : r_tail;
        n_tail    = i_cmd.push ? ptr_inc(wr_addr) : wr_addr;
        rd_addr   = ptr_inc(ptr_inc(n_head));
    end

    wfn_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.push),
        .i_wr_addr (wr_addr),
        .i_wr_data (push_e),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_fwd_hit <= i_cmd.push && (wr_addr == rd_addr);
        end
        r_h0  <= n_h0;
        r_h1  <= n_h1;
        r_fwd <= push_e;
    end

    assign o_stat.head_valid = (r_count != '0);
    assign o_stat.next_valid = (n_count != '0);
    assign o_head_pos        = r_h0[PW-1:0];
    assign o_next_value      = n_h0[EW-1:PW];

endmodule

/* design/window_first_negative.sv */
// Channel  Dir  Fields                         Transaction
// i_in     in   sample, starts_sequence        valid && ready
// o_out    out  first_negative                 valid && ready
// i_cfg    in   window_size                    valid && ready
//
// One sample per cycle unless stalled; its result is registered the cycle after.
// Queue entries live in a one-read one-write memory; the two oldest sit in registers.
// After a window_size write, i_in stalls until every stale head entry is dropped.
// Synchronous reset clears the queue, counters and output valid; window_size resets to 1.
// i_in stalls while a held result is not taken.
module window_first_negative import wfn_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wfn_in_if.sink     i_in,
    wfn_out_if.source  o_out,
    wfn_cfg_if.sink    i_cfg
);

    localparam int PW = $clog2(2 * MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0]        r_ws;
    logic [PW-1:0]           r_pos, n_pos, pos_eff;
    logic [WW-1:0]           r_fill, n_fill, fill_eff, win;
    logic                    r_clean;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_value;
    logic [31:0]             ws_ext;
    logic [PW:0]             diff;
    logic [PW-1:0]           age, head_pos;
    logic                    step, clear, drop, emit, in_ready;
    t_q_cmd                  cmd;
    t_q_stat                 stat;
    logic signed [SAMPLE_WIDTH-1:0] next_value;
    logic signed [63:0]      ext;

    always_comb begin
        ws_ext = 32'(r_ws);
        if (r_ws == '0) begin
            win = WW'(1);
        end else if (ws_ext > 32'(MAX_WINDOW)) begin
            win = WW'(MAX_WINDOW);
        end else begin
            win = WW'(ws_ext);
        end
    end

    assign in_ready = !r_clean && (!r_out_valid || o_out.ready);
    assign step     = i_in.valid && in_ready;
    assign clear    = step && i_in.starts_sequence;

    always_comb begin
        pos_eff  = clear ? '0 : r_pos;
        fill_eff = clear ? '0 : r_fill;
        diff     = {1'b0, pos_eff} - {1'b0, head_pos};
        age      = diff[PW] ? PW'(diff + (PW+1)'(2 * MAX_WINDOW)) : diff[PW-1:0];
        drop     = stat.head_valid && !clear && (age >= PW'(win));
        n_fill   = (fill_eff < win) ? fill_eff + WW'(1) : win;
        n_pos    = (pos_eff == PW'(2 * MAX_WINDOW - 1)) ? '0 : pos_eff + PW'(1);
        emit     = step && (n_fill == win);
        cmd.clear = clear;
        cmd.pop   = drop && (step || r_clean);
        cmd.push  = step && i_in.sample[SAMPLE_WIDTH-1];
        ext       = 64'(next_value);
    end

    wfn_queue #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PW           (PW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_in.sample),
        .i_push_pos   (pos_eff),
        .o_stat       (stat),
        .o_head_pos   (head_pos),
        .o_next_value (next_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= CFG_W'(1);
            r_pos       <= '0;
            r_fill      <= '0;
            r_clean     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
            end
            if (i_cfg.valid) begin
                r_ws    <= i_cfg.window_size;
                r_clean <= 1'b1;
            end else if (r_clean && !drop) begin
                r_clean <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_out_value <= stat.next_valid ? ext[OUT_W-1:0] : '0;
        end
    end

    assign i_in.ready           = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.first_negative = r_out_value;

endmodule
